/* hdl/islip_pkg.sv */
// Shared types and constants of the iSLIP VOQ crossbar scheduler.
package islip_pkg;

    localparam int PORT_W      = 3;
    localparam int LIMIT_W     = 7;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;
    localparam int MASK_W      = 8;
    localparam int TARGETS_W   = 24;
    localparam int COUNT_W     = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ARR    = 6'b000010,
        S_GRANT  = 6'b000100,
        S_ACCEPT = 6'b001000,
        S_DEC    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic arr_load;   // finish arrival: update count, load result
        logic grant_en;   // register grant stage
        logic acc_en;     // register accept stage, move pointers
        logic dec_en;     // decrement sweep step
        logic tick_load;  // load tick result
    } t_cmd;

    typedef struct packed {
        logic dec_last;   // sweep has passed the last input
    } t_sts;

endpackage

/* hdl/islip_voq_crossbar_scheduler.sv */
// Top level of the single-iteration iSLIP scheduler for a VOQ crossbar switch.
//
// Each input transaction is either a cell arrival or a scheduling tick, chosen by
// s_axis_tuser, and yields exactly one result transaction. An arrival reads the VOQ
// count memory in its acceptance cycle; then, once the output register is free, it
// compares against the limit, writes the count back and loads the result. A tick goes
// through the acceptance cycle, the grant arbiters, the accept arbiters and pointer
// update, then a sweep through the count memory (one read and one write port) that
// decrements one matched VOQ per input, and the result load. The next transaction is
// accepted in the cycle after a result load. The output register lets the block accept
// the next transaction while a result waits; a result that is not yet taken holds the
// block before its own result load. VOQ counts need no clearing pass: a per-VOQ
// occupancy bit, cleared at reset, marks empty queues. queue_limit is written through
// i_cfg_we / i_cfg_wdata and resets to 64.
module islip_voq_crossbar_scheduler #(
    parameter int PORTS       = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [2:0] source_port, [5:3] target_port, [7:6] zero
    input  logic [islip_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] mode
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] dropped, [8:1] match_valid_mask, [32:9] match_targets,
    // [36:33] match_count, [39:37] zero
    output logic [islip_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] is_tick_result
    output logic                                  m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [islip_pkg::LIMIT_W-1:0]         i_cfg_wdata
);

    islip_pkg::t_cmd w_cmd;
    islip_pkg::t_sts w_sts;

    islip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    islip_dpath #(
        .PORTS       (PORTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_src    (s_axis_tdata[2:0]),
        .i_in_dst    (s_axis_tdata[5:3]),
        .o_out_data  (m_axis_tdata),
        .o_out_tick  (m_axis_tuser)
    );

endmodule

/* hdl/islip_ctrl.sv */
// Controller state machine of the iSLIP scheduler: sequencing and output handshake.
module islip_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output islip_pkg::t_cmd   o_cmd,
    input  islip_pkg::t_sts   i_sts
);

    islip_pkg::t_state r_state, n_state;
    logic              r_out_vld, n_out_vld;
    logic              w_out_free;
    islip_pkg::t_cmd   w_cmd;

    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            islip_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    n_state = (i_in_mode == islip_pkg::MODE_TICK) ? islip_pkg::S_GRANT
                                                                  : islip_pkg::S_ARR;
                end
            end
            islip_pkg::S_ARR: begin
                if (w_out_free) begin
                    w_cmd.arr_load = 1'b1;
                    n_state = islip_pkg::S_IDLE;
                end
            end
            islip_pkg::S_GRANT: begin
                w_cmd.grant_en = 1'b1;
                n_state = islip_pkg::S_ACCEPT;
            end
            islip_pkg::S_ACCEPT: begin
                w_cmd.acc_en = 1'b1;
                n_state = islip_pkg::S_DEC;
            end
            islip_pkg::S_DEC: begin
                w_cmd.dec_en = 1'b1;
                if (i_sts.dec_last) begin
                    n_state = islip_pkg::S_DONE;
                end
            end
            islip_pkg::S_DONE: begin
                if (w_out_free) begin
                    w_cmd.tick_load = 1'b1;
                    n_state = islip_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = islip_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_cmd.arr_load || w_cmd.tick_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= islip_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == islip_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

endmodule

/* hdl/islip_dpath.sv */
// Datapath of the iSLIP scheduler: VOQ counts, arbiters, pointers and result register.
module islip_dpath #(
    parameter int PORTS       = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  islip_pkg::t_cmd                       i_cmd,
    output islip_pkg::t_sts                       o_sts,
    input  logic                                  i_cfg_we,
    input  logic [islip_pkg::LIMIT_W-1:0]         i_cfg_wdata,
    input  logic [islip_pkg::PORT_W-1:0]          i_in_src,
    input  logic [islip_pkg::PORT_W-1:0]          i_in_dst,
    output logic [islip_pkg::OUT_DATA_W-1:0]      o_out_data,
    output logic                                  o_out_tick
);

    localparam int PW       = $clog2(PORTS);
    localparam int IW       = PW + 1;
    localparam int NQ       = PORTS * PORTS;
    localparam int AW       = $clog2(NQ);
    localparam int MAX_FILL = (QUEUE_DEPTH < 127) ? QUEUE_DEPTH : 127;
    localparam int FW       = $clog2(MAX_FILL + 1);
    localparam int DW       = $clog2(QUEUE_DEPTH + 1);
    localparam int CW       = (DW > islip_pkg::LIMIT_W) ? DW : islip_pkg::LIMIT_W;
    localparam int NV       = (PORTS < 8) ? PORTS : 8;
    localparam int SW       = $clog2(PORTS + 1);

    // Round-robin pick: first requester at or after the pointer; top bit is "found".
    function automatic logic [PW:0] rr_pick(input logic [PORTS-1:0] req,
                                            input logic [PW-1:0]    ptr);
        logic          found;
        logic [PW-1:0] sel;
        logic [IW-1:0] cand;
        found = 1'b0;
        sel   = '0;
        for (int n = PORTS - 1; n >= 0; n--) begin
            cand = {1'b0, ptr} + IW'(n);
            if (cand >= IW'(PORTS)) begin
                cand = cand - IW'(PORTS);
            end
            if (req[cand[PW-1:0]]) begin
                found = 1'b1;
                sel   = cand[PW-1:0];
            end
        end
        return {found, sel};
    endfunction

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] x);
        return (x == PW'(PORTS - 1)) ? '0 : x + PW'(1);
    endfunction

    // Configuration and occupancy state.
    logic [islip_pkg::LIMIT_W-1:0] r_limit;
    logic [NQ-1:0]                 r_nz;      // a VOQ whose bit is clear holds zero cells
    logic [FW-1:0]                 r_mem [NQ];
    logic [FW-1:0]                 r_rd_data;
    logic                          r_rd_nz;

    // Arrival capture.
    logic [AW-1:0]                 r_arr_addr;
    logic                          r_arr_rng;

    // Scheduling state.
    logic [PW-1:0]                 r_gptr [PORTS];
    logic [PW-1:0]                 r_aptr [PORTS];
    logic [PORTS-1:0]              r_gnt_vld;
    logic [PW-1:0]                 r_gnt_in [PORTS];
    logic [PORTS-1:0]              r_m_vld;
    logic [PW-1:0]                 r_m_out [PORTS];

    // Decrement sweep.
    logic [IW-1:0]                 r_idx;
    logic                          r_wp_vld;
    logic [AW-1:0]                 r_wp_addr;

    // Result register.
    logic [islip_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                             r_out_tick;

    logic                          w_in_rng;
    logic [AW-1:0]                 w_in_addr;
    logic                          w_idx_ok;
    logic [PW-1:0]                 w_idx;
    logic [AW-1:0]                 w_sw_addr;
    logic [AW-1:0]                 w_rd_addr;
    logic [FW-1:0]                 w_cnt;
    logic                          w_drop;
    logic                          w_arr_we;
    logic                          w_dec_we;
    logic                          w_we;
    logic [AW-1:0]                 w_wr_addr;
    logic [FW-1:0]                 w_wr_data;
    logic [PORTS-1:0]              w_req_col [PORTS];
    logic [PORTS-1:0]              w_gnt_row [PORTS];
    logic [PORTS-1:0]              w_g_vld;
    logic [PW-1:0]                 w_g_in [PORTS];
    logic [PORTS-1:0]              w_a_vld;
    logic [PW-1:0]                 w_a_out [PORTS];
    logic [PORTS-1:0]              w_g_hit;
    logic [PW:0]                   w_pick_g [PORTS];
    logic [PW:0]                   w_pick_a [PORTS];
    logic [islip_pkg::MASK_W-1:0]     w_mask;
    logic [islip_pkg::TARGETS_W-1:0]  w_targets;
    logic [SW-1:0]                    w_sum;

    // Arrival address; ports beyond the switch are ignored.
    assign w_in_rng  = (5'(i_in_src) < 5'(PORTS)) && (5'(i_in_dst) < 5'(PORTS));
    assign w_in_addr = w_in_rng ? AW'(int'(i_in_src) * PORTS + int'(i_in_dst)) : '0;

    assign w_idx_ok  = (r_idx < IW'(PORTS));
    assign w_idx     = w_idx_ok ? r_idx[PW-1:0] : '0;
    assign w_sw_addr = AW'(int'(w_idx) * PORTS + int'(r_m_out[w_idx]));

    always_comb begin
        if (i_cmd.accept) begin
            w_rd_addr = w_in_addr;
        end else if (i_cmd.dec_en) begin
            w_rd_addr = w_sw_addr;
        end else begin
            w_rd_addr = r_arr_addr;
        end
    end

    assign w_cnt  = r_rd_nz ? r_rd_data : '0;
    assign w_drop = r_arr_rng &&
                    ((CW'(w_cnt) >= CW'(r_limit)) || (CW'(w_cnt) >= CW'(QUEUE_DEPTH)));

    assign w_arr_we  = i_cmd.arr_load && r_arr_rng && !w_drop;
    assign w_dec_we  = i_cmd.dec_en && r_wp_vld;
    assign w_we      = w_arr_we || w_dec_we;
    assign w_wr_addr = w_dec_we ? r_wp_addr : r_arr_addr;
    assign w_wr_data = w_dec_we ? (w_cnt - FW'(1)) : (w_cnt + FW'(1));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
        r_rd_nz   <= r_nz[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= '0;
        end else if (w_arr_we) begin
            r_nz[r_arr_addr] <= 1'b1;
        end else if (w_dec_we && (w_cnt == FW'(1))) begin
            r_nz[r_wp_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= islip_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_arr_addr <= w_in_addr;
            r_arr_rng  <= w_in_rng;
        end
    end

    // Grant stage: each output arbitrates over the inputs holding cells for it.
    always_comb begin
        for (int j = 0; j < PORTS; j++) begin
            for (int i = 0; i < PORTS; i++) begin
                w_req_col[j][i] = r_nz[i * PORTS + j];
            end
            w_pick_g[j] = rr_pick(w_req_col[j], r_gptr[j]);
            w_g_vld[j]  = w_pick_g[j][PW];
            w_g_in[j]   = w_pick_g[j][PW-1:0];
        end
    end

    // Accept stage: each input arbitrates over the outputs that granted it.
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            for (int j = 0; j < PORTS; j++) begin
                w_gnt_row[i][j] = r_gnt_vld[j] && (r_gnt_in[j] == PW'(i));
            end
            w_pick_a[i] = rr_pick(w_gnt_row[i], r_aptr[i]);
            w_a_vld[i]  = w_pick_a[i][PW];
            w_a_out[i]  = w_pick_a[i][PW-1:0];
        end
        for (int j = 0; j < PORTS; j++) begin
            w_g_hit[j] = r_gnt_vld[j] && w_a_vld[r_gnt_in[j]] &&
                         (w_a_out[r_gnt_in[j]] == PW'(j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grant_en) begin
            r_gnt_vld <= w_g_vld;
            r_gnt_in  <= w_g_in;
        end
        if (i_cmd.acc_en) begin
            r_m_vld <= w_a_vld;
            r_m_out <= w_a_out;
        end
    end

    // Pointers move only on an accepted match, one past the partner.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PORTS; k++) begin
                r_gptr[k] <= '0;
                r_aptr[k] <= '0;
            end
        end else if (i_cmd.acc_en) begin
            for (int k = 0; k < PORTS; k++) begin
                if (w_a_vld[k]) begin
                    r_aptr[k] <= ptr_next(w_a_out[k]);
                end
                if (w_g_hit[k]) begin
                    r_gptr[k] <= ptr_next(r_gnt_in[k]);
                end
            end
        end
    end

    // Sweep reads input k's matched VOQ while writing back input k-1's.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_wp_vld <= 1'b0;
        end else if (i_cmd.acc_en) begin
            r_idx    <= '0;
            r_wp_vld <= 1'b0;
        end else if (i_cmd.dec_en) begin
            if (w_idx_ok) begin
                r_idx <= r_idx + IW'(1);
            end
            r_wp_vld <= w_idx_ok && r_m_vld[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec_en) begin
            r_wp_addr <= w_sw_addr;
        end
    end

    assign o_sts.dec_last = !w_idx_ok;

    always_comb begin
        w_mask    = '0;
        w_targets = '0;
        w_sum     = '0;
        for (int i = 0; i < NV; i++) begin
            w_mask[i]        = r_m_vld[i];
            w_targets[3*i +: 3] = r_m_vld[i] ? 3'(r_m_out[i]) : 3'd0;
        end
        for (int i = 0; i < PORTS; i++) begin
            w_sum = w_sum + SW'(r_m_vld[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arr_load) begin
            r_out_data <= {3'd0, 4'd0, 24'd0, 8'd0, w_drop};
            r_out_tick <= islip_pkg::MODE_ARRIVAL;
        end else if (i_cmd.tick_load) begin
            r_out_data <= {3'd0, 4'(w_sum), w_targets, w_mask, 1'b0};
            r_out_tick <= islip_pkg::MODE_TICK;
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_tick = r_out_tick;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the single-iteration iSLIP VOQ crossbar scheduler.
module testbench;

    localparam int PW       = islip_pkg::PORT_W;
    localparam int LW       = islip_pkg::LIMIT_W;
    localparam int TW       = islip_pkg::TARGETS_W;
    localparam int NPORTS   = 1 << PW;
    localparam int QDEPTH   = 64;
    localparam int SETTLE   = NPORTS + 8;
    localparam int WATCHDOG = 5000;

    typedef struct packed {
        bit                            tick;
        bit                            dropped;
        bit [islip_pkg::MASK_W-1:0]    mask;
        bit [islip_pkg::TARGETS_W-1:0] targets;
        bit [islip_pkg::COUNT_W-1:0]   count;
    } t_sched_result;

    // Tracks VOQ fills and round-robin pointers, and holds the results still owed by the block.
    class t_crossbar_tracker;
        int                 fill[NPORTS*NPORTS];
        bit [PW-1:0]        grant_ptr[NPORTS];
        bit [PW-1:0]        accept_ptr[NPORTS];
        bit [LW-1:0]        limit;
        t_sched_result      owed_results[$];
        int                 errors;
        int                 arrivals;
        int                 ticks;
        int                 drops;
        int                 matched;
        int                 settings;

        function new();
            foreach (fill[k]) fill[k] = 0;
            foreach (grant_ptr[k]) grant_ptr[k] = '0;
            foreach (accept_ptr[k]) accept_ptr[k] = '0;
            limit = islip_pkg::LIMIT_RESET;
        endfunction

        function void set_limit(bit [LW-1:0] v);
            limit = v;
            settings++;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function t_sched_result predict_item(bit mode, int src, int dst);
            t_sched_result r;
            int            granted[NPORTS];
            int            cap;
            int            cand;
            int            o;
            int            idx;
            r = '0;
            r.tick = mode;
            if (mode == islip_pkg::MODE_ARRIVAL) begin
                cap = (int'(limit) < QDEPTH) ? int'(limit) : QDEPTH;
                idx = src * NPORTS + dst;
                if (fill[idx] >= cap) begin
                    r.dropped = 1'b1;
                end else begin
                    fill[idx]++;
                end
            end else begin
                // Grant stage: every output picks the first requester from its pointer on.
                for (int j = 0; j < NPORTS; j++) begin
                    granted[j] = -1;
                    for (int n = 0; n < NPORTS; n++) begin
                        cand = (int'(grant_ptr[j]) + n) % NPORTS;
                        if (fill[cand * NPORTS + j] != 0) begin
                            granted[j] = cand;
                            break;
                        end
                    end
                end
                // Accept stage: pointers move only for pairs that end up matched.
                for (int i = 0; i < NPORTS; i++) begin
                    for (int n = 0; n < NPORTS; n++) begin
                        o = (int'(accept_ptr[i]) + n) % NPORTS;
                        if (granted[o] == i) begin
                            accept_ptr[i] = PW'((o + 1) % NPORTS);
                            grant_ptr[o]  = PW'((i + 1) % NPORTS);
                            fill[i * NPORTS + o]--;
                            r.mask[i] = 1'b1;
                            r.targets[3*i +: 3] = o[2:0];
                            r.count++;
                            break;
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_item(bit mode, int src, int dst);
            owed_results.push_back(predict_item(mode, src, dst));
            if (mode == islip_pkg::MODE_ARRIVAL) arrivals++;
            else ticks++;
        endfunction

        function void compare_field(string name, bit [TW-1:0] e, bit [TW-1:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_result(bit tuser, bit [islip_pkg::OUT_DATA_W-1:0] data);
            t_sched_result exp_r;
            t_sched_result got;
            got.tick    = tuser;
            got.dropped = data[0];
            got.mask    = data[8:1];
            got.targets = data[32:9];
            got.count   = data[36:33];
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual tuser %0h tdata %0h",
                         $time, tuser, data);
                return;
            end
            exp_r = owed_results.pop_front();
            compare_field("is_tick_result", TW'(exp_r.tick), TW'(got.tick));
            compare_field("dropped", TW'(exp_r.dropped), TW'(got.dropped));
            compare_field("match_valid_mask", TW'(exp_r.mask), TW'(got.mask));
            compare_field("match_targets", exp_r.targets, got.targets);
            compare_field("match_count", TW'(exp_r.count), TW'(got.count));
            drops   += int'(got.dropped);
            matched += int'(got.count);
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [islip_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic                                s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [islip_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                                m_axis_tuser;
    logic                                i_cfg_we;
    logic [LW-1:0]                       i_cfg_wdata;

    t_crossbar_tracker board;
    bit                gaps_on;
    int                quiet_cycles = 0;

    islip_voq_crossbar_scheduler #(
        .PORTS       (NPORTS),
        .QUEUE_DEPTH (QDEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Any cycle without a transaction on either side counts toward the timeout.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_item(bit mode, int src, int dst);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 13)) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, PW'(dst), PW'(src)};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(mode, src, dst);
    endtask

    task automatic send_tick();
        send_item(islip_pkg::MODE_TICK, int'($urandom_range(0, NPORTS-1)),
                  int'($urandom_range(0, NPORTS-1)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(int v);
        drain();
        // An idle wait separates the last result from the register write.
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LW'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_limit(LW'(v));
    endtask

    task automatic run_phase(int lim, int count, int arr_pct, int hot_pct,
                             bit idle, bit hold_mid);
        int              hot_src;
        int              hot_dst;
        int              src;
        int              dst;
        bit              mode;
        int              k;
        write_limit(lim);
        gaps_on = idle;
        hot_src = int'($urandom_range(0, NPORTS-1));
        hot_dst = int'($urandom_range(0, NPORTS-1));
        for (k = 0; k < count; k++) begin
            if (hold_mid && k == count / 2) drain();
            src  = int'($urandom_range(0, NPORTS-1));
            dst  = int'($urandom_range(0, NPORTS-1));
            mode = (int'($urandom_range(0, 99)) < arr_pct) ? islip_pkg::MODE_ARRIVAL
                                                            : islip_pkg::MODE_TICK;
            // Hot-spot arrivals pile onto one queue so that it reaches the limit.
            if (mode == islip_pkg::MODE_ARRIVAL && int'($urandom_range(0, 99)) < hot_pct) begin
                src = hot_src;
                dst = hot_dst;
            end
            send_item(mode, src, dst);
        end
    endtask

    // Result side: random stalls, then take and check one result transaction.
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        forever begin
            stall = gaps_on ? int'($urandom_range(0, 13)) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            board.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    initial begin
        board         = new();
        gaps_on       = 1'b1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= islip_pkg::MODE_ARRIVAL;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Limit of one: second cell to a queue drops, corner ports, drain to empty.
        write_limit(1);
        send_item(islip_pkg::MODE_ARRIVAL, 0, 0);
        send_item(islip_pkg::MODE_ARRIVAL, 0, 0);
        send_item(islip_pkg::MODE_ARRIVAL, 7, 7);
        send_item(islip_pkg::MODE_ARRIVAL, 7, 0);
        send_item(islip_pkg::MODE_ARRIVAL, 0, 7);
        send_item(islip_pkg::MODE_ARRIVAL, 3, 5);
        send_item(islip_pkg::MODE_ARRIVAL, 5, 3);
        send_tick();
        send_tick();
        send_tick();
        send_tick();

        // Limit of zero drops every arrival; a tick with all-ones fields is ignored.
        write_limit(0);
        send_item(islip_pkg::MODE_ARRIVAL, 4, 4);
        send_item(islip_pkg::MODE_ARRIVAL, 7, 7);
        send_item(islip_pkg::MODE_TICK, 7, 7);

        // Limit above the queue depth; contention on one output, and one input
        // receiving two grants of which only one is accepted.
        write_limit(127);
        send_item(islip_pkg::MODE_ARRIVAL, 1, 2);
        send_item(islip_pkg::MODE_ARRIVAL, 1, 2);
        send_item(islip_pkg::MODE_ARRIVAL, 2, 2);
        send_item(islip_pkg::MODE_ARRIVAL, 6, 1);
        send_item(islip_pkg::MODE_ARRIVAL, 6, 4);
        send_tick();
        send_tick();
        send_tick();

        run_phase(64, 200, 60, 0, 1'b1, 1'b0);
        run_phase(1, 200, 55, 0, 1'b1, 1'b1);
        run_phase(127, 220, 90, 80, 1'b1, 1'b0);
        run_phase(2, 200, 70, 20, 1'b0, 1'b0);
        run_phase(0, 120, 50, 0, 1'b1, 1'b0);
        run_phase(3, 200, 75, 30, 1'b1, 1'b1);
        run_phase(100, 220, 92, 85, 1'b0, 1'b0);
        run_phase(int'($urandom_range(1, 64)), 270, 60, 10, 1'b1, 1'b0);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d arrivals (%0d dropped) and %0d ticks (%0d pairs matched)",
                 board.arrivals, board.drops, board.ticks, board.matched);
        $display("across %0d queue_limit settings, with and without handshake gaps.",
                 board.settings);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/islip_pkg.sv
hdl/islip_ctrl.sv
hdl/islip_dpath.sv
hdl/islip_voq_crossbar_scheduler.sv
bench/testbench.sv
